// ===== hdl/mspd_pkg.sv =====
// ----------------------------------------------------------------------------
// mspd_pkg: shared constants and types for the Mode S preamble detector
// Window geometry, field widths and the candidate record passed between the
// window stage and the scoring stage.
// ----------------------------------------------------------------------------
package mspd_pkg;

  // Sample and position sizing
  localparam int unsigned SampleBits   = 16;
  localparam int unsigned PositionBits = 32;

  // Port field widths
  localparam int unsigned SampleInW = 16;
  localparam int unsigned GainW     = 10;
  localparam int unsigned StartOutW = 32;
  localparam int unsigned LevelOutW = 20;
  localparam int unsigned RefOutW   = 24;

  // Window: previous samples held, plus the current one
  localparam int unsigned WindowDepth = 24;
  localparam int unsigned FillW       = $clog2(WindowDepth + 1);
  localparam int unsigned GainShift   = 5;
  localparam logic [GainW-1:0] GainReset = GainW'(58);

  // Sums of up to eight samples
  localparam int unsigned SumW   = SampleBits + 3;
  localparam int unsigned LevelW = SumW + 1;
  localparam int unsigned ProdW  = SumW + GainW;
  localparam int unsigned RefW   = ProdW - GainShift;

  typedef logic [SampleBits-1:0] sample_t;

  // Candidate that passed the pulse/quiet shape test
  typedef struct packed {
    logic [PositionBits-1:0] start;
    logic [SumW-1:0]         pulse;
    logic [SumW-1:0]         quiet;
  } cand_t;

endpackage

// ===== hdl/mspd_window.sv =====
// ----------------------------------------------------------------------------
// mspd_window: sample window, fill and position tracking, shape test
// Shifts samples into a 24-deep tap line, checks the pulse/quiet ordering
// on the full 25-sample window and registers the sums of a candidate.
// ----------------------------------------------------------------------------
module mspd_window
  import mspd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SampleInW-1:0] sample_i,
  input  logic                 buffer_start_i,
  output logic                 cand_valid_o,
  input  logic                 cand_ready_i,
  output cand_t                cand_o
);

  sample_t                 win_q [WindowDepth];
  sample_t                 p [WindowDepth+1];
  sample_t                 smp;
  logic [FillW-1:0]        fill_q, fill_d, fill_cur;
  logic [PositionBits-1:0] pos_q, pos_d, pos_cur;
  logic                    cand_valid_q, cand_valid_d;
  cand_t                   cand_q, cand_d;
  logic                    accept, full, shape_ok;

  assign smp        = sample_i[SampleBits-1:0];
  assign in_ready_o = !cand_valid_q || cand_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Buffer start empties the window and restarts the index
  assign fill_cur = buffer_start_i ? '0 : fill_q;
  assign pos_cur  = buffer_start_i ? '0 : pos_q;
  assign full     = (fill_cur == FillW'(WindowDepth));
  assign fill_d   = full ? fill_cur : fill_cur + FillW'(1);
  assign pos_d    = pos_cur + PositionBits'(1);

  // Full window view, oldest first, current sample last
  always_comb begin
    for (int i = 0; i < WindowDepth; i++) begin
      p[i] = win_q[i];
    end
    p[WindowDepth] = smp;
  end

  // Pulse positions must stand above the quiet positions
  assign shape_ok = (p[1] > p[9]) && (p[5] > p[9]) && (p[15] > p[24]) && (p[19] > p[24]);

  // Sums and start index of the candidate
  always_comb begin
    cand_d.quiet = SumW'(p[8]) + SumW'(p[9]) + SumW'(p[10])
                 + SumW'(p[22]) + SumW'(p[23]) + SumW'(p[24]);
    cand_d.pulse = SumW'(p[0]) + SumW'(p[1]) + SumW'(p[4]) + SumW'(p[5])
                 + SumW'(p[14]) + SumW'(p[15]) + SumW'(p[18]) + SumW'(p[19]);
    cand_d.start = pos_cur - PositionBits'(WindowDepth);
  end

  // Candidate register handshake
  always_comb begin
    cand_valid_d = cand_valid_q;
    if (accept) begin
      cand_valid_d = full && shape_ok;
    end else if (cand_ready_i) begin
      cand_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      pos_q        <= '0;
      cand_valid_q <= 1'b0;
    end else begin
      cand_valid_q <= cand_valid_d;
      if (accept) begin
        fill_q <= fill_d;
        pos_q  <= pos_d;
      end
    end
  end

  // Tap line and candidate payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < WindowDepth - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WindowDepth-1] <= smp;
      cand_q <= cand_d;
    end
  end

  assign cand_valid_o = cand_valid_q;
  assign cand_o       = cand_q;

endmodule

// ===== hdl/mspd_score.sv =====
// ----------------------------------------------------------------------------
// mspd_score: threshold scoring and result register
// Scales the quiet sum by the gain, compares the preamble level against it
// and holds a hit in the output register until it is taken.
// ----------------------------------------------------------------------------
module mspd_score
  import mspd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [GainW-1:0]      gain_i,
  input  logic                  cand_valid_i,
  output logic                  cand_ready_o,
  input  cand_t                 cand_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [StartOutW-1:0]  start_position_o,
  output logic [LevelOutW-1:0]  preamble_level_o,
  output logic [RefOutW-1:0]    reference_level_o
);

  logic [ProdW-1:0]         prod;
  logic [RefW-1:0]          ref_lvl;
  logic signed [LevelW-1:0] level;
  logic                     hit, take;
  logic                     out_valid_q, out_valid_d;
  logic [StartOutW-1:0]     start_q;
  logic [LevelOutW-1:0]     level_q;
  logic [RefOutW-1:0]       ref_q;

  assign cand_ready_o = !out_valid_q || out_ready_i;
  assign take         = cand_valid_i && cand_ready_o;

  // Reference level and signed preamble level
  assign prod    = ProdW'(cand_i.quiet) * ProdW'(gain_i);
  assign ref_lvl = prod[ProdW-1:GainShift];
  assign level   = $signed({1'b0, cand_i.pulse}) - $signed({1'b0, cand_i.quiet});

  // A negative level never reaches the reference
  assign hit = !level[LevelW-1] && (RefW'(level[SumW-1:0]) >= ref_lvl);

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = hit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      start_q <= StartOutW'(cand_i.start);
      level_q <= LevelOutW'(level);
      ref_q   <= RefOutW'(ref_lvl);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign start_position_o  = start_q;
  assign preamble_level_o  = level_q;
  assign reference_level_o = ref_q;

endmodule

// ===== hdl/mode_s_preamble_detector.sv =====
// ----------------------------------------------------------------------------
// mode_s_preamble_detector: Mode S preamble search on a 4 MHz magnitude stream
//
//   channel   signals                                         direction
//   input     in_valid_i/in_ready_o, sample_i, buffer_start_i  request in
//   result    out_valid_o/out_ready_i, start_position_o,       request out
//             preamble_level_o, reference_level_o
//   config    cfg_we_i, cfg_wdata_i (threshold_gain)           write only
//
// One sample is accepted per cycle while in_ready_o is high. A sample is
// tested in the cycle it is accepted; its sums go to the candidate register,
// and the gain multiply and compare feed the result register, from which a
// hit is shown for the sample that completes its window. Reset empties the
// window and sets the gain to 58. A held result stalls the candidate stage,
// which then stalls input; each stage still moves while the one after it drains.
// ----------------------------------------------------------------------------
module mode_s_preamble_detector
  import mspd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [GainW-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SampleInW-1:0] sample_i,
  input  logic                 buffer_start_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [StartOutW-1:0] start_position_o,
  output logic [LevelOutW-1:0] preamble_level_o,
  output logic [RefOutW-1:0]   reference_level_o
);

  logic [GainW-1:0] gain_q;
  logic             cand_valid, cand_ready;
  cand_t            cand;

  // Threshold gain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  mspd_window u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .buffer_start_i (buffer_start_i),
    .cand_valid_o   (cand_valid),
    .cand_ready_i   (cand_ready),
    .cand_o         (cand)
  );

  mspd_score u_score (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .gain_i            (gain_q),
    .cand_valid_i      (cand_valid),
    .cand_ready_o      (cand_ready),
    .cand_i            (cand),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .start_position_o  (start_position_o),
    .preamble_level_o  (preamble_level_o),
    .reference_level_o (reference_level_o)
  );

  // A buffer start empties the window, so no candidate can follow it
  a_no_cand_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && buffer_start_i) |=> !cand_valid)
    else $error("candidate raised right after a buffer start");

  // A stalled candidate keeps its sums
  a_cand_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cand_valid && !cand_ready) |=> (cand_valid && $stable(cand)))
    else $error("stalled candidate changed");

  // Every reported hit has a non-negative level at or above the reference
  a_hit_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!preamble_level_o[LevelOutW-1]
                     && (RefOutW'(preamble_level_o) >= reference_level_o)))
    else $error("reported level below reference");

  // Input is refused only while the candidate stage is stalled
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (cand_valid && !cand_ready && out_valid_o && !out_ready_i))
    else $error("input stalled without a downstream stall");

endmodule
